@@ design/wsd_pkg.sv @@
// Shared definitions for the WebSocket frame deframer.
// Holds the default length width, the length codes, the byte-counter end values and the result struct.
// No dependencies.
package wsd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 64;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Value of the byte counter on the last byte of each multi-byte field.
    localparam logic [2:0] LAST_EXT16_COUNT = 3'd1;
    localparam logic [2:0] LAST_EXT64_COUNT = 3'd7;
    localparam logic [2:0] LAST_KEY_COUNT   = 3'd3;

    typedef struct packed {
        logic       has_result;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_end;
        logic [3:0] frame_opcode;
        logic       final_fragment;
    } t_result;

endpackage

@@ design/websocket_frame_deframer.sv @@
// WebSocket frame deframer top level: byte handshake and output register.
// Output: each result is registered and appears in the cycle after the beat that causes it.
// Throughput: one byte per cycle while the output is not held; the single parse-state update per beat sets this.
// The input stalls while a result waits and is not taken; it passes when taken that cycle.
// Reset: synchronous, active low; the parser expects header byte one afterward.
// Depends on wsd_pkg and wsd_parser.
module websocket_frame_deframer #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_stream_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_byte_valid,
    output logic       o_frame_end,
    output logic [3:0] o_frame_opcode,
    output logic       o_final_fragment
);

    logic             w_accept;
    wsd_pkg::t_result w_result;
    logic             r_out_valid;
    wsd_pkg::t_result r_out;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    wsd_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_accept),
        .i_stream_byte(i_stream_byte),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= w_accept && w_result.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_result.has_result) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_byte_valid     = r_out.byte_valid;
    assign o_frame_end      = r_out.frame_end;
    assign o_frame_opcode   = r_out.frame_opcode;
    assign o_final_fragment = r_out.final_fragment;

endmodule

@@ design/wsd_parser.sv @@
// Frame header parser and payload unmasking for the WebSocket deframer.
// Holds all parse state and produces at most one result per input beat.
// Depends on wsd_pkg.
module wsd_parser #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_stream_byte,
    output wsd_pkg::t_result o_result
);

    typedef enum logic [5:0] {
        PH_HDR1  = 6'b000001,
        PH_HDR2  = 6'b000010,
        PH_LEN16 = 6'b000100,
        PH_LEN64 = 6'b001000,
        PH_KEY   = 6'b010000,
        PH_DATA  = 6'b100000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_count, n_count;
    logic [LENGTH_BITS-1:0] r_remaining, n_remaining;
    logic [31:0]            r_key, n_key;
    logic                   r_mask_present, n_mask_present;
    logic [1:0]             r_position, n_position;
    logic [3:0]             r_opcode, n_opcode;
    logic                   r_final, n_final;

    logic                   w_hdr_done;
    logic                   w_len_zero;
    logic                   w_len_done;
    logic [7:0]             w_key_byte;
    logic [6:0]             w_len7;
    wsd_pkg::t_result       w_result;

    always_comb begin
        case (r_position)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_count        = r_count;
        n_remaining    = r_remaining;
        n_key          = r_key;
        n_mask_present = r_mask_present;
        n_position     = r_position;
        n_opcode       = r_opcode;
        n_final        = r_final;
        w_hdr_done     = 1'b0;
        w_len_zero     = 1'b0;
        w_len_done     = 1'b0;
        w_len7         = i_stream_byte[6:0];
        w_result       = '0;
        w_result.frame_opcode   = r_opcode;
        w_result.final_fragment = r_final;

        case (r_phase)
            PH_HDR2: begin
                n_mask_present = i_stream_byte[7];
                n_key          = '0;
                n_count        = '0;
                n_remaining    = '0;
                if (w_len7 == wsd_pkg::LEN_CODE_EXT16) begin
                    n_phase = PH_LEN16;
                end else if (w_len7 == wsd_pkg::LEN_CODE_EXT64) begin
                    n_phase = PH_LEN64;
                end else begin
                    n_remaining = LENGTH_BITS'(w_len7);
                    w_len_done  = 1'b1;
                    w_len_zero  = (w_len7 == 7'd0);
                end
            end
            PH_LEN16, PH_LEN64: begin
                n_remaining = {r_remaining[LENGTH_BITS-9:0], i_stream_byte};
                n_count     = r_count + 3'd1;
                w_len_zero  = (n_remaining == '0);
                if (r_phase == PH_LEN16) begin
                    w_len_done = (r_count == wsd_pkg::LAST_EXT16_COUNT);
                end else begin
                    w_len_done = (r_count == wsd_pkg::LAST_EXT64_COUNT);
                end
            end
            PH_KEY: begin
                n_key   = {r_key[23:0], i_stream_byte};
                n_count = r_count + 3'd1;
                if (r_count >= wsd_pkg::LAST_KEY_COUNT) begin
                    w_hdr_done = 1'b1;
                    w_len_zero = (r_remaining == '0);
                end
            end
            PH_DATA: begin
                n_position              = r_position + 2'd1;
                n_remaining             = r_remaining - LENGTH_BITS'(1);
                w_result.has_result     = 1'b1;
                w_result.byte_valid     = 1'b1;
                w_result.payload_byte   = i_stream_byte ^ w_key_byte;
                if (r_remaining == LENGTH_BITS'(1)) begin
                    n_phase            = PH_HDR1;
                    w_result.frame_end = 1'b1;
                end
            end
            default: begin
                n_final  = i_stream_byte[7];
                n_opcode = i_stream_byte[3:0];
                n_count  = '0;
                n_phase  = PH_HDR2;
            end
        endcase

        // A finished length goes on to the key when the mask flag is set.
        if (w_len_done) begin
            n_count = '0;
            if (n_mask_present) begin
                n_phase = PH_KEY;
            end else begin
                w_hdr_done = 1'b1;
            end
        end

        if (w_hdr_done) begin
            n_position = '0;
            n_count    = '0;
            if (w_len_zero) begin
                n_phase             = PH_HDR1;
                w_result.has_result = 1'b1;
                w_result.frame_end  = 1'b1;
            end else begin
                n_phase = PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR1;
            r_count        <= '0;
            r_remaining    <= '0;
            r_key          <= '0;
            r_mask_present <= 1'b0;
            r_position     <= '0;
            r_opcode       <= '0;
            r_final        <= 1'b0;
        end else if (i_advance) begin
            r_phase        <= n_phase;
            r_count        <= n_count;
            r_remaining    <= n_remaining;
            r_key          <= n_key;
            r_mask_present <= n_mask_present;
            r_position     <= n_position;
            r_opcode       <= n_opcode;
            r_final        <= n_final;
        end
    end

    assign o_result = w_result;

endmodule
